/* hw/rtl/r2k_pkg.sv */
// ----------------------------------------------------------------------------
// r2k_pkg
// Shared widths, constants and the romaji table for the kana converter.
// ----------------------------------------------------------------------------
package r2k_pkg;

  localparam int CODE_W        = 21;
  localparam int LOOKAHEAD_DEF = 3;
  localparam int ROM_N         = 107;
  localparam int ROM_IDX_W     = 7;

  localparam logic [CODE_W-1:0] KANA_N    = 21'h03093;
  localparam logic [CODE_W-1:0] SMALL_TSU = 21'h03063;
  localparam logic [CODE_W-1:0] MARU      = 21'h0309C;
  localparam logic [CODE_W-1:0] CH_DASH   = 21'h0002D;
  localparam logic [CODE_W-1:0] CH_N      = 21'h0006E;
  localparam logic [CODE_W-1:0] CH_Y      = 21'h00079;
  localparam logic [CODE_W-1:0] CH_C      = 21'h00063;
  localparam logic [CODE_W-1:0] CH_P      = 21'h00070;
  localparam logic [CODE_W-1:0] CH_S      = 21'h00073;
  localparam logic [CODE_W-1:0] CH_T      = 21'h00074;
  localparam logic [CODE_W-1:0] CH_K      = 21'h0006B;

  // one table row: letters (zero = unused), kana pair (second zero = none)
  typedef struct packed {
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [15:0] k0;
    logic [15:0] k1;
  } rom_row_t;

  // command from controller to datapath
  typedef struct packed {
    logic load;     // store accepted character
    logic resolve;  // resolve leading position, latch results
    logic emit;     // present next pending result
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       need_resolve;  // buffer full or draining at end of text
    logic       more_pending;  // results still waiting after current one
  } dp_sts_t;

  function automatic rom_row_t mk(input string s, input logic [15:0] a,
                                  input logic [15:0] b);
    rom_row_t r;
    r.c0 = s.len() > 0 ? s[0] : 8'd0;
    r.c1 = s.len() > 1 ? s[1] : 8'd0;
    r.c2 = s.len() > 2 ? s[2] : 8'd0;
    r.k0 = a;
    r.k1 = b;
    return r;
  endfunction

  function automatic rom_row_t rom_row(input logic [ROM_IDX_W-1:0] i);
    rom_row_t r;
    case (i)
      7'd0:   r = mk("a", 16'h3042, 16'h0);
      7'd1:   r = mk("i", 16'h3044, 16'h0);
      7'd2:   r = mk("u", 16'h3046, 16'h0);
      7'd3:   r = mk("e", 16'h3048, 16'h0);
      7'd4:   r = mk("o", 16'h304A, 16'h0);
      7'd5:   r = mk("ka", 16'h304B, 16'h0);
      7'd6:   r = mk("ki", 16'h304D, 16'h0);
      7'd7:   r = mk("ku", 16'h304F, 16'h0);
      7'd8:   r = mk("ke", 16'h3051, 16'h0);
      7'd9:   r = mk("ko", 16'h3053, 16'h0);
      7'd10:  r = mk("sa", 16'h3055, 16'h0);
      7'd11:  r = mk("si", 16'h3057, 16'h0);
      7'd12:  r = mk("su", 16'h3059, 16'h0);
      7'd13:  r = mk("se", 16'h305B, 16'h0);
      7'd14:  r = mk("so", 16'h305D, 16'h0);
      7'd15:  r = mk("shi", 16'h3057, 16'h0);
      7'd16:  r = mk("ta", 16'h305F, 16'h0);
      7'd17:  r = mk("ti", 16'h3061, 16'h0);
      7'd18:  r = mk("tu", 16'h3064, 16'h0);
      7'd19:  r = mk("te", 16'h3066, 16'h0);
      7'd20:  r = mk("to", 16'h3068, 16'h0);
      7'd21:  r = mk("chi", 16'h3061, 16'h0);
      7'd22:  r = mk("tsu", 16'h3064, 16'h0);
      7'd23:  r = mk("na", 16'h306A, 16'h0);
      7'd24:  r = mk("ni", 16'h306B, 16'h0);
      7'd25:  r = mk("nu", 16'h306C, 16'h0);
      7'd26:  r = mk("ne", 16'h306D, 16'h0);
      7'd27:  r = mk("no", 16'h306E, 16'h0);
      7'd28:  r = mk("ha", 16'h306F, 16'h0);
      7'd29:  r = mk("hi", 16'h3072, 16'h0);
      7'd30:  r = mk("fu", 16'h3075, 16'h0);
      7'd31:  r = mk("he", 16'h3078, 16'h0);
      7'd32:  r = mk("ho", 16'h307B, 16'h0);
      7'd33:  r = mk("ma", 16'h307E, 16'h0);
      7'd34:  r = mk("mi", 16'h307F, 16'h0);
      7'd35:  r = mk("mu", 16'h3080, 16'h0);
      7'd36:  r = mk("me", 16'h3081, 16'h0);
      7'd37:  r = mk("mo", 16'h3082, 16'h0);
      7'd38:  r = mk("ya", 16'h3084, 16'h0);
      7'd39:  r = mk("yu", 16'h3086, 16'h0);
      7'd40:  r = mk("yo", 16'h3088, 16'h0);
      7'd41:  r = mk("ra", 16'h3089, 16'h0);
      7'd42:  r = mk("ri", 16'h308A, 16'h0);
      7'd43:  r = mk("ru", 16'h308B, 16'h0);
      7'd44:  r = mk("re", 16'h308C, 16'h0);
      7'd45:  r = mk("ro", 16'h308D, 16'h0);
      7'd46:  r = mk("wa", 16'h308F, 16'h0);
      7'd47:  r = mk("wo", 16'h3092, 16'h0);
      7'd48:  r = mk("ga", 16'h304C, 16'h0);
      7'd49:  r = mk("gi", 16'h304E, 16'h0);
      7'd50:  r = mk("gu", 16'h3050, 16'h0);
      7'd51:  r = mk("ge", 16'h3052, 16'h0);
      7'd52:  r = mk("go", 16'h3054, 16'h0);
      7'd53:  r = mk("za", 16'h3056, 16'h0);
      7'd54:  r = mk("ji", 16'h3058, 16'h0);
      7'd55:  r = mk("zu", 16'h305A, 16'h0);
      7'd56:  r = mk("ze", 16'h305C, 16'h0);
      7'd57:  r = mk("zo", 16'h305E, 16'h0);
      7'd58:  r = mk("da", 16'h3060, 16'h0);
      7'd59:  r = mk("di", 16'h3062, 16'h0);
      7'd60:  r = mk("du", 16'h3065, 16'h0);
      7'd61:  r = mk("de", 16'h3067, 16'h0);
      7'd62:  r = mk("do", 16'h3069, 16'h0);
      7'd63:  r = mk("ba", 16'h3070, 16'h0);
      7'd64:  r = mk("bi", 16'h3073, 16'h0);
      7'd65:  r = mk("bu", 16'h3076, 16'h0);
      7'd66:  r = mk("be", 16'h3079, 16'h0);
      7'd67:  r = mk("bo", 16'h307C, 16'h0);
      7'd68:  r = mk("pa", 16'h3071, 16'h0);
      7'd69:  r = mk("pi", 16'h3074, 16'h0);
      7'd70:  r = mk("pu", 16'h3077, 16'h0);
      7'd71:  r = mk("pe", 16'h307A, 16'h0);
      7'd72:  r = mk("po", 16'h307D, 16'h0);
      7'd73:  r = mk("kya", 16'h304D, 16'h3083);
      7'd74:  r = mk("kyu", 16'h304D, 16'h3085);
      7'd75:  r = mk("kyo", 16'h304D, 16'h3087);
      7'd76:  r = mk("sha", 16'h3057, 16'h3083);
      7'd77:  r = mk("shu", 16'h3057, 16'h3085);
      7'd78:  r = mk("sho", 16'h3057, 16'h3087);
      7'd79:  r = mk("cha", 16'h3061, 16'h3083);
      7'd80:  r = mk("chu", 16'h3061, 16'h3085);
      7'd81:  r = mk("cho", 16'h3061, 16'h3087);
      7'd82:  r = mk("nya", 16'h306B, 16'h3083);
      7'd83:  r = mk("nyu", 16'h306B, 16'h3085);
      7'd84:  r = mk("nyo", 16'h306B, 16'h3087);
      7'd85:  r = mk("hya", 16'h3072, 16'h3083);
      7'd86:  r = mk("hyu", 16'h3072, 16'h3085);
      7'd87:  r = mk("hyo", 16'h3072, 16'h3087);
      7'd88:  r = mk("mya", 16'h307F, 16'h3083);
      7'd89:  r = mk("myu", 16'h307F, 16'h3085);
      7'd90:  r = mk("myo", 16'h307F, 16'h3087);
      7'd91:  r = mk("rya", 16'h308A, 16'h3083);
      7'd92:  r = mk("ryu", 16'h308A, 16'h3085);
      7'd93:  r = mk("ryo", 16'h308A, 16'h3087);
      7'd94:  r = mk("gya", 16'h304E, 16'h3083);
      7'd95:  r = mk("gyu", 16'h304E, 16'h3085);
      7'd96:  r = mk("gyo", 16'h304E, 16'h3087);
      7'd97:  r = mk("ja", 16'h3058, 16'h3083);
      7'd98:  r = mk("ju", 16'h3058, 16'h3085);
      7'd99:  r = mk("jo", 16'h3058, 16'h3087);
      7'd100: r = mk("bya", 16'h3073, 16'h3083);
      7'd101: r = mk("byu", 16'h3073, 16'h3085);
      7'd102: r = mk("byo", 16'h3073, 16'h3087);
      7'd103: r = mk("pya", 16'h3074, 16'h3083);
      7'd104: r = mk("pyu", 16'h3074, 16'h3085);
      7'd105: r = mk("pyo", 16'h3074, 16'h3087);
      7'd106: r = mk("nn", 16'h3093, 16'h0);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/r2k_ctrl.sv */
// ----------------------------------------------------------------------------
// r2k_ctrl
// Sequencer: load, resolve positions one by one, hand out results.
// ----------------------------------------------------------------------------
module r2k_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_fire,
  input  r2k_pkg::dp_sts_t sts,
  output logic             in_ready,
  output logic             out_valid,
  output r2k_pkg::dp_cmd_t cmd
);
  import r2k_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SHOW} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_SHOW);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.need_resolve) begin
          cmd.resolve = 1'b1;
          state_nxt   = S_SHOW;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SHOW: begin
        if (out_fire) begin
          cmd.emit = 1'b1;
          if (!sts.more_pending) state_nxt = S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

/* hw/rtl/r2k_dp.sv */
// ----------------------------------------------------------------------------
// r2k_dp
// Look-ahead buffer, table match and result latch.
// ----------------------------------------------------------------------------
module r2k_dp #(
  parameter int DEPTH = r2k_pkg::LOOKAHEAD_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  r2k_pkg::dp_cmd_t          cmd,
  input  logic [r2k_pkg::CODE_W-1:0] in_code,
  input  logic                      in_eot,
  input  logic                      full_text,
  output r2k_pkg::dp_sts_t          sts,
  output logic [r2k_pkg::CODE_W-1:0] out_code,
  output logic                      out_run_end,
  output logic                      out_text_end
);
  import r2k_pkg::*;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [CODE_W-1:0] buf_r [DEPTH];
  logic [CW-1:0]     cnt_r;
  logic              eot_r;
  logic [CODE_W-1:0] p0_r, p1_r;
  logic              two_r, sel_r;

  // match: first row whose letters equal the leading characters
  logic              hit;
  rom_row_t          row;
  logic [1:0]        len;
  logic              has1, has2;
  logic [CODE_W-1:0] c0, c1, c2;

  assign c0   = buf_r[0];
  assign c1   = buf_r[1];
  assign c2   = buf_r[2];
  assign has1 = cnt_r > CW'(1);
  assign has2 = cnt_r > CW'(2);

  always_comb begin
    rom_row_t r;
    logic ok;
    hit = 1'b0;
    row = '0;
    for (int e = ROM_N - 1; e >= 0; e--) begin
      r  = rom_row(ROM_IDX_W'(e));
      ok = (c0 == CODE_W'(r.c0)) &&
           (r.c1 == 8'd0 || (has1 && c1 == CODE_W'(r.c1))) &&
           (r.c2 == 8'd0 || (has2 && c2 == CODE_W'(r.c2)));
      if (ok) begin
        hit = 1'b1;
        row = r;
      end
    end
    len = (row.c2 != 8'd0) ? 2'd3 : (row.c1 != 8'd0) ? 2'd2 : 2'd1;
  end

  logic [CODE_W-1:0] r0;
  logic              rtwo;
  logic [1:0]        used;
  logic              dbl;

  always_comb begin
    dbl  = (c0 == CH_C || c0 == CH_P || c0 == CH_S || c0 == CH_T || c0 == CH_K)
           && has1 && c1 == c0;
    rtwo = 1'b0;
    used = 2'd1;
    if (c0 == CH_DASH) r0 = MARU;
    else if (hit) begin
      r0   = CODE_W'(row.k0);
      rtwo = row.k1 != 16'd0;
      used = len;
    end else if (c0 == CH_N && (full_text || has1) && !(has1 && c1 == CH_Y))
      r0 = KANA_N;
    else if (dbl) r0 = SMALL_TSU;
    else r0 = c0;
  end

  logic [CW-1:0] cnt_after;
  assign cnt_after = cnt_r - CW'(used);

  assign sts.need_resolve = (cnt_r != '0) && (eot_r || cnt_r >= CW'(DEPTH));
  assign sts.more_pending = two_r && !sel_r;

  // last result of the step: no further resolve will follow
  logic last;
  assign last = !sts.more_pending &&
                !((cnt_r != '0) && (eot_r || cnt_r >= CW'(DEPTH)));

  assign out_code     = sel_r ? p1_r : p0_r;
  assign out_run_end  = last;
  assign out_text_end = last && eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      eot_r <= 1'b0;
      sel_r <= 1'b0;
      two_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) buf_r[i] <= '0;
    end else begin
      if (cmd.load) begin
        if (cnt_r >= CW'(DEPTH)) begin
          buf_r[DEPTH-1] <= in_code;
          cnt_r          <= CW'(DEPTH);
        end else begin
          buf_r[cnt_r[IW-1:0]] <= in_code;
          cnt_r                <= cnt_r + CW'(1);
        end
        eot_r <= in_eot;
      end
      if (cmd.resolve) begin
        p0_r  <= r0;
        p1_r  <= CODE_W'(row.k1);
        two_r <= rtwo;
        sel_r <= 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
          if (i + int'(used) < int'(cnt_r)) buf_r[i] <= buf_r[i + int'(used)];
          else buf_r[i] <= '0;
        end
        cnt_r <= (CW'(used) > cnt_r) ? '0 : cnt_after;
      end
      if (cmd.emit) sel_r <= sts.more_pending;
    end
  end
endmodule

/* hw/rtl/romaji_to_kana_stream.sv */
// ----------------------------------------------------------------------------
// romaji_to_kana_stream
// Streaming romaji to hiragana converter with a small look-ahead buffer.
// ----------------------------------------------------------------------------
// channel | dir | tdata                 | tuser
// in_     | in  | [20:0] char_code      | [0] end_of_text
// out_    | out | [20:0] out_code       | [0] run_end, [1] text_end
// cfg_    | in  | cfg_wdata = full_text | -
//
// An item is loaded in S_IDLE; S_CHECK then resolves positions one by one, and
// S_SHOW hands out each result before the next resolve. The single
// resolve/match unit over the table ROM serializes this work.
// in_tready is low until every result of the previous transfer is taken.
// A stalled out_ holds its data. Reset empties the buffer, full_text = 0.
// ----------------------------------------------------------------------------
module romaji_to_kana_stream #(
  parameter int LOOKAHEAD_DEPTH = r2k_pkg::LOOKAHEAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] char_code
  input  logic        in_tuser,   // [0] end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] out_code
  output logic [1:0]  out_tuser,  // [0] run_end, [1] text_end
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import r2k_pkg::*;

  logic              full_text_r;
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [CODE_W-1:0] code;
  logic              run_end, text_end;
  logic              in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n)      full_text_r <= 1'b0;
    else if (cfg_we) full_text_r <= cfg_wdata;
  end

  r2k_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts,
    .in_ready(in_tready), .out_valid(out_tvalid), .cmd
  );

  r2k_dp #(.DEPTH(LOOKAHEAD_DEPTH)) u_dp (
    .clk, .rst_n, .cmd,
    .in_code(in_tdata[CODE_W-1:0]), .in_eot(in_tuser),
    .full_text(full_text_r), .sts,
    .out_code(code), .out_run_end(run_end), .out_text_end(text_end)
  );

  assign out_tdata = {3'b000, code};
  assign out_tuser = {text_end, run_end};

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output both open");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_te: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0]) else $error("text end w/o run end");
`endif
endmodule

/* bench/romaji_to_kana_stream_tb.sv */
// ----------------------------------------------------------------------------
// romaji_to_kana_stream_tb
// Self-checking bench for the romaji to hiragana converter. Texts are sent as
// character transfers and every output code is checked against a predictor
// that keeps its own look-ahead buffer and full_text copy.
// ----------------------------------------------------------------------------
module romaji_to_kana_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import r2k_pkg::*;

  localparam int DEPTH = LOOKAHEAD_DEF;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eot;
  } char_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              run_end;
    logic              text_end;
  } kana_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  romaji_to_kana_stream uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // pending characters, expected kana, predictor state
  char_item_t        char_q[$];
  kana_item_t        kana_q[$];
  logic [CODE_W-1:0] la_buf[DEPTH];
  int                la_cnt;
  logic              full_text_m;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;   // long receiver hold-off, counted by monitor
  int mismatches    = 0;
  int n_chars       = 0;
  int n_kana        = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic peek_at(int i, output logic [CODE_W-1:0] v);
    v = '0;
    if (i < la_cnt) begin
      v = la_buf[i];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_kana(logic [CODE_W-1:0] c);
    kana_item_t k;
    k.code = c;
    k.run_end = 1'b0;
    k.text_end = 1'b0;
    kana_q.push_back(k);
  endfunction

  // resolve leading buffer position, returns letters consumed
  function automatic int resolve_lead();
    logic [CODE_W-1:0] c0, c1, v;
    logic              has1, ok;
    rom_row_t          r;
    logic [7:0]        lt[3];
    int                len;
    c0 = la_buf[0];
    has1 = peek_at(1, c1);
    if (c0 == CH_DASH) begin
      push_kana(MARU);
      return 1;
    end
    for (int e = 0; e < ROM_N; e++) begin
      r = rom_row(e[ROM_IDX_W-1:0]);
      lt[0] = r.c0; lt[1] = r.c1; lt[2] = r.c2;
      ok = 1'b1;
      len = 0;
      for (int j = 0; j < 3; j++) begin
        if (lt[j] == 8'd0) break;
        len++;
        if (!peek_at(j, v) || v != {13'd0, lt[j]}) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok) begin
        push_kana({5'd0, r.k0});
        if (r.k1 != 16'd0) push_kana({5'd0, r.k1});
        return len;
      end
    end
    if (c0 == CH_N && (full_text_m || has1) && !(has1 && c1 == CH_Y)) begin
      push_kana(KANA_N);
      return 1;
    end
    if ((c0 == CH_C || c0 == CH_P || c0 == CH_S || c0 == CH_T || c0 == CH_K)
        && has1 && c1 == c0) begin
      push_kana(SMALL_TSU);
      return 1;
    end
    push_kana(c0);
    return 1;
  endfunction

  function automatic void predict_kana(char_item_t it);
    int used, base;
    base = kana_q.size();
    if (la_cnt >= DEPTH) la_cnt = DEPTH - 1;
    la_buf[la_cnt] = it.code;
    la_cnt++;
    while (la_cnt > 0 && (it.eot || la_cnt >= DEPTH)) begin
      used = resolve_lead();
      if (used > la_cnt) used = la_cnt;
      for (int i = 0; i < DEPTH; i++)
        la_buf[i] = (i + used < la_cnt) ? la_buf[i + used] : '0;
      la_cnt -= used;
    end
    if (kana_q.size() > base) begin
      kana_q[$].run_end = 1'b1;
      kana_q[$].text_end = it.eot;
    end
  endfunction

  // ---------------------------------------------------------------- driver
  // predicts at the transfer, so expectation always precedes the result;
  // the head of the queue is the item on the bus until its transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_kana('{code: in_tdata[CODE_W-1:0], eot: in_tuser});
        void'(char_q.pop_front());
        n_chars++;
      end
      if ((!in_tvalid || in_tready) && char_q.size() > 0) begin
        if ($urandom_range(99) < send_idle_pct) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= {3'd0, char_q[0].code};
          in_tuser  <= char_q[0].eot;
        end
      end else if (in_tvalid && in_tready) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    kana_item_t exp_k;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_kana++;
        if (kana_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected output code %h", out_tdata[CODE_W-1:0]);
        end else begin
          exp_k = kana_q.pop_front();
          if (exp_k.code != out_tdata[CODE_W-1:0] || exp_k.run_end != out_tuser[0]
              || exp_k.text_end != out_tuser[1]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: code exp %h got %h, run_end exp %b got %b, text_end exp %b got %b",
                       exp_k.code, out_tdata[CODE_W-1:0], exp_k.run_end, out_tuser[0],
                       exp_k.text_end, out_tuser[1]);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void add_text(string s, logic end_it);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.code = {13'd0, s[i]};
      it.eot = end_it && (i == s.len() - 1);
      char_q.push_back(it);
    end
  endfunction

  function automatic void add_code(logic [CODE_W-1:0] c, logic e);
    char_q.push_back('{code: c, eot: e});
  endfunction

  // random well-formed syllable or noise character
  function automatic void add_random_text(int len);
    string sy[] = '{"ka", "shi", "tsu", "chi", "nya", "kyo", "ryu", "pyo", "n",
                    "nn", "-", "kk", "tt", "ss", "pp", "cc", "ja", "fu", "wo", "ny",
                    "a", "e", "y", "x", "q", "sh", "ch"};
    int k;
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(99);
      if (k < 75) begin
        add_text(sy[$urandom_range(sy.size() - 1)], 1'b0);
      end else if (k < 85) begin
        add_code(CODE_W'($urandom_range(8'h7a, 8'h61)), 1'b0);
      end else if (k < 95) begin
        add_code(CODE_W'($urandom_range(21'h1FFFFF, 0)), 1'b0);
      end else begin
        add_code(CODE_W'($urandom_range(127, 0)), 1'b0);
      end
    end
    char_q[$].eot = 1'b1;
  endfunction

  task automatic wait_drained();
    while (char_q.size() != 0 || in_tvalid || kana_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_full_text(logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    full_text_m = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    la_cnt = 0;
    full_text_m = 1'b0;
    for (int i = 0; i < DEPTH; i++) la_buf[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: table hits, fallbacks, extremes, trailing n with register 0
    add_text("kyoto", 1'b1);
    add_text("shinnya-", 1'b1);
    add_text("kitte", 1'b1);
    add_text("hon", 1'b1);
    add_code(21'h000000, 1'b0);
    add_code(21'h1FFFFF, 1'b1);
    add_text("n", 1'b1);
    wait_drained();
    write_full_text(1'b1);
    add_text("hon", 1'b1);
    add_text("ny", 1'b1);
    add_code(21'h0AAAAA, 1'b0);
    add_code(21'h155555, 1'b1);
    wait_drained();
    write_full_text(1'b0);

    // sender idles less than receiver; long hold-off to back up the block
    send_idle_pct = 22; recv_idle_pct = 58;
    hold_cycles = 300;
    while (n_chars < 140) begin
      add_random_text($urandom_range(12, 1));
      while (char_q.size() > 4) @(posedge clk);
    end
    wait_drained();
    write_full_text(1'b1);
    send_idle_pct = 58; recv_idle_pct = 22;
    while (n_chars < 260) begin
      add_random_text($urandom_range(12, 1));
      while (char_q.size() > 4) @(posedge clk);
    end
    wait_drained();
    write_full_text(1'b0);
    send_idle_pct = 0; recv_idle_pct = 0;
    while (n_chars < 340) begin
      add_random_text($urandom_range(12, 1));
      while (char_q.size() > 4) @(posedge clk);
    end
    wait_drained();

    $display("Covered %0d characters in, %0d codes out, full_text both ways,", n_chars,
             n_kana);
    $display("with idle mixes on both sides and a long output hold-off.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
